@@ rtl/swos_pkg.sv @@
// Package with the shared types and constants of the weighted order selector.
`timescale 1ns / 1ps
`default_nettype none
package swos_pkg;

    localparam int PRIO_W = 16;
    localparam int WGT_W  = 16;
    localparam int TAG_W  = 8;
    localparam int RND_W  = 31;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_DRAW  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [WGT_W-1:0]  weight;
        logic [TAG_W-1:0]  tag;
    } rec_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_TAKE_NEXT,
        CELL_LOAD,
        CELL_CLEAR,
        CELL_KILL
    } cell_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MIN,
        S_SUM,
        S_DIV,
        S_SEL0,
        S_SEL1,
        S_REMOVE,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

@@ rtl/swos_if.sv @@
// Handshake interfaces for the input and result channels of the selector.
`timescale 1ns / 1ps
`default_nettype none
interface swos_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] rec_priority;
    logic [15:0] rec_weight;
    logic [7:0]  rec_tag;
    logic [30:0] random_value;

    modport source (output valid, opcode, rec_priority, rec_weight, rec_tag, random_value,
                    input ready);
    modport sink (input valid, opcode, rec_priority, rec_weight, rec_tag, random_value,
                  output ready);
endinterface

interface swos_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_tag;
    logic [15:0] out_priority;
    logic [15:0] out_weight;
    logic        none_left;
    logic        final_record;
    logic        store_full;

    modport source (output valid, out_tag, out_priority, out_weight, none_left,
                    final_record, store_full, input ready);
    modport sink (input valid, out_tag, out_priority, out_weight, none_left,
                  final_record, store_full, output ready);
endinterface
`default_nettype wire

@@ rtl/swos_cell.sv @@
// One record cell of the chain: holds a record and its live bit.
`timescale 1ns / 1ps
`default_nettype none
module swos_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  swos_pkg::cell_mode_t mode,
    input  swos_pkg::rec_t       next_rec,
    input  wire                  next_live,
    input  swos_pkg::rec_t       load_rec,
    output swos_pkg::rec_t       rec,
    output logic                 live
);
    import swos_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;
    logic live_reg;
    logic live_next;

    always_comb
    begin
        rec_next  = rec_reg;
        live_next = live_reg;
        case (mode)
            CELL_HOLD:
            begin
                rec_next  = rec_reg;
                live_next = live_reg;
            end
            CELL_TAKE_NEXT:
            begin
                rec_next  = next_rec;
                live_next = next_live;
            end
            CELL_LOAD:
            begin
                rec_next  = load_rec;
                live_next = 1'b1;
            end
            CELL_CLEAR, CELL_KILL:
            begin
                live_next = 1'b0;
            end
            default:
            begin
                live_next = live_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec  = rec_reg;
    assign live = live_reg;
endmodule
`default_nettype wire

@@ rtl/srv_weighted_order_selector.sv @@
// Top level of the weighted service-record selector: cell chain and sequencer.
//
//   channel | role   | beat carries
//   in_ch   | sink   | opcode, rec_priority, rec_weight, rec_tag, random_value
//   out_ch  | source | out_tag, out_priority, out_weight, none_left, final_record, store_full
//
// A load's result passes the execute and result steps into the output register,
// and a clear holds the input for its execute step after acceptance. A draw
// runs from acceptance to result through these steps:
// the record chain rotates once to find the lowest priority, once to sum its
// weights and twice to pick the record, and the modulo runs one bit a cycle
// over 31 bits.
// Reset clears the live bits and the count at once; no clearing pass is needed.
// The result waits in an output register, so a stalled sink only holds the
// sequencer at its final step.
`timescale 1ns / 1ps
`default_nettype none
module srv_weighted_order_selector #(
    parameter int MAX_RECORDS = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    swos_in_if.sink    in_ch,
    swos_out_if.source out_ch
);
    import swos_pkg::*;

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int SUM_W = WGT_W + $clog2(MAX_RECORDS);
    localparam int REM_W = SUM_W + 1;
    localparam int BIT_W = $clog2(RND_W);

    // Cell chain. Each cell takes its upper neighbour on a rotation, so after
    // t rotations the head cell holds the record of slot t.
    cell_mode_t cell_mode [MAX_RECORDS];
    rec_t       cell_rec  [MAX_RECORDS];
    logic       cell_live [MAX_RECORDS];
    rec_t       load_rec;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++)
        begin : g_cell
            swos_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .mode      (cell_mode[gi]),
                .next_rec  (cell_rec[(gi + 1) % MAX_RECORDS]),
                .next_live (cell_live[(gi + 1) % MAX_RECORDS]),
                .load_rec  (load_rec),
                .rec       (cell_rec[gi]),
                .live      (cell_live[gi])
            );
        end
    endgenerate

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  sel_reg, sel_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic              found_reg, found_next;
    logic [PRIO_W-1:0] min_reg, min_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  run_reg, run_next;
    logic [REM_W-1:0]  rem_reg, rem_next;

    logic [OP_W-1:0]   op_reg, op_next;
    rec_t              item_reg, item_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;

    rec_t              res_rec_reg, res_rec_next;
    logic              res_none_reg, res_none_next;
    logic              res_final_reg, res_final_next;
    logic              res_full_reg, res_full_next;

    logic              out_valid_reg, out_valid_next;
    rec_t              out_rec_reg, out_rec_next;
    logic              out_none_reg, out_none_next;
    logic              out_final_reg, out_final_next;
    logic              out_full_reg, out_full_next;

    rec_t              head_rec;
    logic              head_live;
    logic              scan_last;
    logic [REM_W-1:0]  divisor;
    logic [REM_W:0]    trial;
    logic              qualify;

    assign head_rec  = cell_rec[0];
    assign head_live = cell_live[0];
    assign scan_last = (k_reg == IDX_W'(MAX_RECORDS - 1));
    assign divisor   = {1'b0, sum_reg} + REM_W'(1);
    assign trial     = {rem_reg, rnd_reg[bit_reg]};
    assign load_rec  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        sel_next       = sel_reg;
        bit_next       = bit_reg;
        found_next     = found_reg;
        min_next       = min_reg;
        sum_next       = sum_reg;
        run_next       = run_reg;
        rem_next       = rem_reg;
        op_next        = op_reg;
        item_next      = item_reg;
        rnd_next       = rnd_reg;
        res_rec_next   = res_rec_reg;
        res_none_next  = res_none_reg;
        res_final_next = res_final_reg;
        res_full_next  = res_full_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_rec_next   = out_rec_reg;
        out_none_next  = out_none_reg;
        out_final_next = out_final_reg;
        out_full_next  = out_full_reg;
        qualify        = 1'b0;
        for (int i = 0; i < MAX_RECORDS; i++)
        begin
            cell_mode[i] = CELL_HOLD;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next     = in_ch.opcode;
                    item_next   = '{prio: in_ch.rec_priority, weight: in_ch.rec_weight,
                                    tag: in_ch.rec_tag};
                    rnd_next    = in_ch.random_value;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_rec_next   = '0;
                res_none_next  = 1'b0;
                res_final_next = 1'b0;
                res_full_next  = 1'b0;
                state_next     = S_IDLE;
                case (op_reg)
                    OP_LOAD:
                    begin
                        if (count_reg == CNT_W'(MAX_RECORDS))
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < MAX_RECORDS; i++)
                            begin
                                if (CNT_W'(i) == count_reg)
                                begin
                                    cell_mode[i] = CELL_LOAD;
                                end
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = S_OUT;
                    end
                    OP_DRAW:
                    begin
                        if (count_reg == '0)
                        begin
                            res_none_next = 1'b1;
                            state_next    = S_OUT;
                        end
                        else
                        begin
                            min_next   = '1;
                            k_next     = '0;
                            state_next = S_MIN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        for (int i = 0; i < MAX_RECORDS; i++)
                        begin
                            cell_mode[i] = CELL_CLEAR;
                        end
                        count_next = '0;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MIN:
            begin
                for (int i = 0; i < MAX_RECORDS; i++)
                begin
                    cell_mode[i] = CELL_TAKE_NEXT;
                end
                if (head_live && head_rec.prio < min_reg)
                begin
                    min_next = head_rec.prio;
                end
                k_next = k_reg + IDX_W'(1);
                if (scan_last)
                begin
                    k_next     = '0;
                    sum_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                for (int i = 0; i < MAX_RECORDS; i++)
                begin
                    cell_mode[i] = CELL_TAKE_NEXT;
                end
                if (head_live && head_rec.prio == min_reg)
                begin
                    sum_next = sum_reg + SUM_W'(head_rec.weight);
                end
                k_next = k_reg + IDX_W'(1);
                if (scan_last)
                begin
                    k_next     = '0;
                    rem_next   = '0;
                    bit_next   = BIT_W'(RND_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring remainder, one dividend bit a cycle.
                if (trial >= {1'b0, divisor})
                begin
                    rem_next = REM_W'(trial - {1'b0, divisor});
                end
                else
                begin
                    rem_next = REM_W'(trial);
                end
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    run_next   = '0;
                    found_next = 1'b0;
                    k_next     = '0;
                    state_next = S_SEL0;
                end
            end
            S_SEL0, S_SEL1:
            begin
                for (int i = 0; i < MAX_RECORDS; i++)
                begin
                    cell_mode[i] = CELL_TAKE_NEXT;
                end
                // The first pass walks the zero-weight records, the second the rest.
                qualify = head_live && (head_rec.prio == min_reg) &&
                          ((head_rec.weight == '0) == (state_reg == S_SEL0));
                if (qualify)
                begin
                    run_next = run_reg + SUM_W'(head_rec.weight);
                    if (!found_reg && ({1'b0, run_next} >= rem_reg))
                    begin
                        found_next   = 1'b1;
                        sel_next     = k_reg;
                        res_rec_next = head_rec;
                    end
                end
                k_next = k_reg + IDX_W'(1);
                if (scan_last)
                begin
                    k_next     = '0;
                    state_next = (state_reg == S_SEL0) ? S_SEL1 : S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                for (int i = 0; i < MAX_RECORDS; i++)
                begin
                    if (i == MAX_RECORDS - 1)
                    begin
                        cell_mode[i] = CELL_KILL;
                    end
                    else if (IDX_W'(i) >= sel_reg)
                    begin
                        cell_mode[i] = CELL_TAKE_NEXT;
                    end
                end
                count_next     = count_reg - CNT_W'(1);
                res_final_next = (count_reg == CNT_W'(1));
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rec_next   = res_rec_reg;
                    out_none_next  = res_none_reg;
                    out_final_next = res_final_reg;
                    out_full_next  = res_full_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        sel_reg       <= sel_next;
        bit_reg       <= bit_next;
        found_reg     <= found_next;
        min_reg       <= min_next;
        sum_reg       <= sum_next;
        run_reg       <= run_next;
        rem_reg       <= rem_next;
        op_reg        <= op_next;
        item_reg      <= item_next;
        rnd_reg       <= rnd_next;
        res_rec_reg   <= res_rec_next;
        res_none_reg  <= res_none_next;
        res_final_reg <= res_final_next;
        res_full_reg  <= res_full_next;
        out_rec_reg   <= out_rec_next;
        out_none_reg  <= out_none_next;
        out_final_reg <= out_final_next;
        out_full_reg  <= out_full_next;
    end

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_tag      = out_rec_reg.tag;
    assign out_ch.out_priority = out_rec_reg.prio;
    assign out_ch.out_weight   = out_rec_reg.weight;
    assign out_ch.none_left    = out_none_reg;
    assign out_ch.final_record = out_final_reg;
    assign out_ch.store_full   = out_full_reg;

    // The count never passes the depth of the chain.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond store depth");

    // Between items the head cell is live exactly when records are held.
    a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cell_live[0] == (count_reg != '0)))
        else $error("head cell live bit disagrees with record count");

    // Removing a record always leads straight to the result step.
    a_remove_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |=> (state_reg == S_OUT))
        else $error("remove step not followed by result step");

    // An empty-store result carries no record and no final flag.
    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_none_reg) |-> (!out_final_reg && out_rec_reg == '0))
        else $error("empty-store result carries record data");
endmodule
`default_nettype wire

@@ bench/swos_checker.sv @@
// Checker that predicts the selector's results from the input beats and compares them.
`timescale 1ns / 1ps
module swos_checker #(
    parameter int MAX_RECORDS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    swos_in_if          in_ch,
    swos_out_if         out_ch,
    output int          fail_count,
    output int          pending_count,
    output int          held_count,
    output int          draws_seen,
    output int          fulls_seen,
    output int          empties_seen
);
    import swos_pkg::*;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] prio;
        logic [15:0] weight;
        logic        none_left;
        logic        final_record;
        logic        store_full;
    } draw_result_t;

    rec_t         held_recs[$];
    draw_result_t awaited_results[$];

    assign pending_count = awaited_results.size();
    assign held_count    = held_recs.size();

    // Works out the result of one draw and removes the chosen record.
    function automatic draw_result_t draw_record(logic [30:0] rnd);
        draw_result_t res;
        logic [15:0]  minp;
        logic [31:0]  total;
        logic [31:0]  r;
        logic [31:0]  run;
        int           sel;
        res = '0;
        if (held_recs.size() == 0)
        begin
            res.none_left = 1'b1;
            return res;
        end
        minp = 16'hFFFF;
        foreach (held_recs[i])
            if (held_recs[i].prio < minp)
                minp = held_recs[i].prio;
        total = 0;
        foreach (held_recs[i])
            if (held_recs[i].prio == minp)
                total += held_recs[i].weight;
        r   = {1'b0, rnd} % (total + 1);
        run = 0;
        sel = -1;
        // Zero-weight records come first, then weighted ones, each in arrival order.
        for (int pass = 0; pass < 2; pass++)
            foreach (held_recs[i])
                if (held_recs[i].prio == minp && ((held_recs[i].weight == 0) == (pass == 0)))
                begin
                    run += held_recs[i].weight;
                    if (sel < 0 && run >= r)
                        sel = i;
                end
        if (sel < 0)
            sel = 0;
        res.tag    = held_recs[sel].tag;
        res.prio   = held_recs[sel].prio;
        res.weight = held_recs[sel].weight;
        held_recs.delete(sel);
        res.final_record = (held_recs.size() == 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_recs.delete();
            awaited_results.delete();
            fail_count   <= 0;
            draws_seen   <= 0;
            fulls_seen   <= 0;
            empties_seen <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                draw_result_t got;
                draw_result_t want;
                got = '{out_ch.out_tag, out_ch.out_priority, out_ch.out_weight,
                        out_ch.none_left, out_ch.final_record, out_ch.store_full};
                if (awaited_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result beat %p", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                draw_result_t res;
                res = '0;
                case (in_ch.opcode)
                    OP_LOAD:
                    begin
                        if (held_recs.size() >= MAX_RECORDS)
                        begin
                            res.store_full = 1'b1;
                            fulls_seen <= fulls_seen + 1;
                        end
                        else
                            held_recs.push_back('{in_ch.rec_priority, in_ch.rec_weight,
                                                  in_ch.rec_tag});
                        awaited_results.push_back(res);
                    end
                    OP_DRAW:
                    begin
                        res = draw_record(in_ch.random_value);
                        draws_seen <= draws_seen + 1;
                        if (res.none_left)
                            empties_seen <= empties_seen + 1;
                        awaited_results.push_back(res);
                    end
                    OP_CLEAR:
                        held_recs.delete();
                    default:
                        ;
                endcase
            end
        end
    end

endmodule

@@ bench/srv_weighted_order_selector_tb.sv @@
// Top of the selector testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module srv_weighted_order_selector_tb;
    import swos_pkg::*;

    localparam int MAX_RECORDS = 16;
    // A draw runs four chain rotations and the modulo; leave generous margin after the last result.
    localparam int DRAIN_CYCLES = 4 * MAX_RECORDS + 60;

    logic clk;
    logic rst_n;

    swos_in_if  in_ch ();
    swos_out_if out_ch ();

    int fail_count;
    int pending_count;
    int held_count;
    int draws_seen;
    int fulls_seen;
    int empties_seen;
    int beats_sent;

    // The receiver's stall pattern is switched off while a long hold-off is in force.
    logic hold_off;

    srv_weighted_order_selector #(.MAX_RECORDS(MAX_RECORDS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    swos_checker #(.MAX_RECORDS(MAX_RECORDS)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .held_count    (held_count),
        .draws_seen    (draws_seen),
        .fulls_seen    (fulls_seen),
        .empties_seen  (empties_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: phases of always-ready, random stalls and a mostly stalled receiver,
    // plus a long hold-off requested by the stimulus.
    initial
    begin
        int mode_left;
        int mode;
        out_ch.ready = 1'b0;
        mode_left = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (mode == 0)
                out_ch.ready <= 1'b1;
            else if (mode == 1)
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                out_ch.ready <= ($urandom_range(0, 9) == 0);
        end
    end

    // Offers one beat and waits until it is accepted; valid stays high into the next beat.
    task automatic send_beat(op_t op, logic [15:0] prio, logic [15:0] weight,
                             logic [7:0] tag, logic [30:0] rnd);
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.rec_priority <= prio;
        in_ch.rec_weight   <= weight;
        in_ch.rec_tag      <= tag;
        in_ch.random_value <= rnd;
        do
            @(posedge clk);
        while (!in_ch.ready);
        beats_sent++;
    endtask

    // Sender idles for the given cycles; valid is lowered here and in drain. A gap of
    // zero leaves valid high so the next burst follows straight on.
    task automatic idle_gap(int cycles);
        if (cycles > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Waits until every awaited result has come and the block has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_random(bit narrow);
        logic [15:0] prio;
        logic [15:0] weight;
        prio   = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        weight = ($urandom_range(0, 4) == 0) ? 16'd0 :
                 (narrow ? 16'($urandom_range(1, 20)) : 16'($urandom));
        send_beat(OP_LOAD, prio, weight, 8'($urandom), 31'($urandom));
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 48)
            load_random($urandom_range(0, 3) != 0);
        else if (pick < 92)
            send_beat(OP_DRAW, 16'($urandom), 16'($urandom), 8'($urandom), 31'($urandom));
        else if (pick < 96)
            send_beat(OP_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom), 31'($urandom));
        else
            // Unused opcode: the block ignores it.
            send_beat(op_t'(2'd3), 16'($urandom), 16'($urandom), 8'($urandom), 31'($urandom));
    endtask

    initial
    begin
        int burst;
        rst_n              = 1'b0;
        hold_off           = 1'b0;
        beats_sent         = 0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_LOAD;
        in_ch.rec_priority = '0;
        in_ch.rec_weight   = '0;
        in_ch.rec_tag      = '0;
        in_ch.random_value = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a draw on an empty store, extreme field values, the
        // zero-weight-first ordering, a full store and a clear.
        send_beat(OP_DRAW, 16'd0, 16'd0, 8'd0, 31'h7FFF_FFFF);
        send_beat(OP_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF, 31'h7FFF_FFFF);
        send_beat(OP_LOAD, 16'd0, 16'd0, 8'h00, 31'd0);
        send_beat(OP_LOAD, 16'd0, 16'd5, 8'h11, 31'd0);
        send_beat(OP_LOAD, 16'd0, 16'd0, 8'h22, 31'd0);
        send_beat(OP_DRAW, 16'd0, 16'd0, 8'd0, 31'd0);
        send_beat(OP_DRAW, 16'hFFFF, 16'hFFFF, 8'hFF, 31'h7FFF_FFFF);
        send_beat(OP_DRAW, 16'd0, 16'd0, 8'd0, 31'd3);
        send_beat(OP_DRAW, 16'd0, 16'd0, 8'd0, 31'd1);
        send_beat(op_t'(2'd3), 16'hFFFF, 16'hFFFF, 8'hFF, 31'h7FFF_FFFF);
        for (int i = 0; i < MAX_RECORDS + 2; i++)
            send_beat(OP_LOAD, 16'(i % 3), 16'(i * 1000), 8'(i), 31'd0);
        send_beat(OP_CLEAR, 16'd0, 16'd0, 8'd0, 31'd0);
        send_beat(OP_DRAW, 16'd0, 16'd0, 8'd0, 31'h2AAA_AAAA);

        // Long receiver hold-off while the sender keeps offering beats, so
        // that the output register fills and the input is stalled.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (12) random_item();
        join

        // Sender pause until every awaited result has come.
        drain();

        while (beats_sent < 850)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst) random_item();
            if ($urandom_range(0, 3) == 0)
                idle_gap(0);
            else
                idle_gap($urandom_range(1, 60));
        end
        drain();

        $display("Sent %0d beats: %0d draws (%0d on an empty store), %0d loads refused as full.",
                 beats_sent, draws_seen, empties_seen, fulls_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("Timed out with %0d results outstanding.", pending_count);
        $display("== FAIL ==");
        $finish;
    end

endmodule
